FILE: hdl/wcm_pkg.sv
// Shared types, constants and the cosine table of the wall column texel mapper.
`timescale 1ns / 1ps
package wcm_pkg;

   localparam int TILE_PIXELS_DEF = 32;
   localparam int ANGLE_BITS_DEF  = 12;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] REG_PLANE_DISTANCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_ROWS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEXTURE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TEXTURE_HEIGHT = 3'd3;

   localparam logic [11:0] PLANE_DISTANCE_RST = 12'd277;
   localparam logic [6:0]  MAP_ROWS_RST       = 7'd10;
   localparam logic [10:0] TEXTURE_WIDTH_RST  = 11'd64;
   localparam logic [10:0] TEXTURE_HEIGHT_RST = 11'd64;

   localparam logic [1:0] TEX_NORTH = 2'd0;
   localparam logic [1:0] TEX_SOUTH = 2'd1;
   localparam logic [1:0] TEX_EAST  = 2'd2;
   localparam logic [1:0] TEX_WEST  = 2'd3;

   // texel column remainder, wall height and texel row chain geometry
   localparam int CRD_W  = 17;
   localparam int TCOL_W = 11;
   localparam int CD_W   = 39;
   localparam int HGT_W  = 24;
   localparam int TROW_Q = 11;

   localparam logic [HGT_W-1:0] HEIGHT_SAT = 24'hFFFFFF;
   localparam logic [9:0]       FIELD_MAX  = 10'd1023;

   typedef struct packed {
      logic [23:0]      ray_dist;
      logic [14:0]      cmag;
      logic             cpos;
      logic [1:0]       sel;
      logic [9:0]       col;
      logic [9:0]       row;
      logic [9:0]       tcol;
      logic [HGT_W-1:0] h8;
      logic             sat;
      logic             draw;
      logic             ovf;
   } wcm_side_type;

   localparam int SIDE_W = $bits(wcm_side_type);

   // quarter-wave cosine, Q1.14, 17 points; anything past the end reads zero
   function automatic logic [14:0] cos_entry(input logic [4:0] idx);
      logic [14:0] v;
      case (idx)
         5'd0:  v = 15'd16384;
         5'd1:  v = 15'd16305;
         5'd2:  v = 15'd16069;
         5'd3:  v = 15'd15679;
         5'd4:  v = 15'd15137;
         5'd5:  v = 15'd14449;
         5'd6:  v = 15'd13623;
         5'd7:  v = 15'd12665;
         5'd8:  v = 15'd11585;
         5'd9:  v = 15'd10394;
         5'd10: v = 15'd9102;
         5'd11: v = 15'd7723;
         5'd12: v = 15'd6270;
         5'd13: v = 15'd4756;
         5'd14: v = 15'd3196;
         5'd15: v = 15'd1606;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/wcm_div_cell.sv
// One restoring divide cell: one quotient bit per stage, handing its result to the next cell.
`timescale 1ns / 1ps
module wcm_div_cell #(
   parameter int RW = 8,
   parameter int DW = 8,
   parameter int QW = 8,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [RW-1:0] in_rem,
   input  logic [DW-1:0] in_dvd,
   input  logic [RW-1:0] in_den,
   input  logic [QW-1:0] in_quo,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [RW-1:0] out_rem,
   output logic [DW-1:0] out_dvd,
   output logic [RW-1:0] out_den,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in, den_ff;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [SW-1:0] side_ff;
   logic [RW:0]   trial, diff;
   logic          ge;
   logic          en;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      trial  = {in_rem, in_dvd[DW-1]};
      diff   = trial - {1'b0, in_den};
      ge     = trial >= {1'b0, in_den};
      rem_in = ge ? diff[RW-1:0] : trial[RW-1:0];
      quo_in = QW'({in_quo, ge});
      dvd_in = in_dvd << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dvd   = dvd_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

FILE: hdl/wcm_front.sv
// Front stage: fish-eye cosine, texture select and rounded hit coordinate.
`timescale 1ns / 1ps
module wcm_front #(
   parameter int ANGLE_BITS = wcm_pkg::ANGLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [23:0]                  ray_distance,
   input  logic [11:0]                  ray_angle,
   input  logic [11:0]                  view_angle,
   input  logic [23:0]                  hit_x,
   input  logic [23:0]                  hit_y,
   input  logic                         hit_vertical,
   input  logic                         face_west_or_north,
   input  logic [9:0]                   screen_column,
   input  logic [9:0]                   screen_row,
   output logic                         out_valid,
   input  logic                         out_ready,
   output wcm_pkg::wcm_side_type        out_side,
   output logic [wcm_pkg::CRD_W-1:0]    out_coord
);

   logic                      valid_ff;
   wcm_pkg::wcm_side_type     side_ff, side_in;
   logic [wcm_pkg::CRD_W-1:0] coord_ff, coord_in;
   logic [15:0]               diff16, a16;
   logic [1:0]                quad;
   logic [14:0]               x;
   logic [4:0]                idx;
   logic [9:0]                frac;
   logic [14:0]               c0, c1, cmag;
   logic [10:0]               dstep;
   logic [21:0]               prod;
   logic [11:0]               corr;
   logic [23:0]               coord;
   logic [24:0]               rsum;
   logic                      en;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      // scale the angle difference to a 16-bit turn; the shift drops the wrap bits
      diff16 = {4'b0, ray_angle} - {4'b0, view_angle};
      a16    = diff16 << (16 - ANGLE_BITS);
      quad   = a16[15:14];
      x      = quad[0] ? (15'h4000 - {1'b0, a16[13:0]}) : {1'b0, a16[13:0]};
      idx    = x[14:10];
      frac   = x[9:0];
      c0     = wcm_pkg::cos_entry(idx);
      c1     = wcm_pkg::cos_entry(idx + 5'd1);
      dstep  = 11'(c0 - c1);
      prod   = 22'(dstep) * 22'(frac);
      corr   = 12'((prod + 22'd512) >> 10);
      cmag   = c0 - 15'(corr);

      coord    = hit_vertical ? hit_y : hit_x;
      rsum     = {1'b0, coord} + 25'd128;
      coord_in = rsum[24:8];

      side_in          = '0;
      side_in.ray_dist = ray_distance;
      side_in.cmag     = cmag;
      side_in.cpos     = (quad[1] == quad[0]) && (cmag != 15'd0);
      side_in.col      = screen_column;
      side_in.row      = screen_row;
      if (hit_vertical) begin
         side_in.sel = face_west_or_north ? wcm_pkg::TEX_WEST : wcm_pkg::TEX_EAST;
      end else begin
         side_in.sel = face_west_or_north ? wcm_pkg::TEX_NORTH : wcm_pkg::TEX_SOUTH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= side_in;
         coord_ff <= coord_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_coord = coord_ff;

endmodule

FILE: hdl/wcm_slice.sv
// Slice placement, draw decision and setup of the texel row division.
`timescale 1ns / 1ps
module wcm_slice #(
   parameter int TILE_PIXELS = wcm_pkg::TILE_PIXELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [wcm_pkg::HGT_W-1:0]     in_quo,
   input  wcm_pkg::wcm_side_type         in_side,
   input  logic [6:0]                    map_rows,
   input  logic [10:0]                   texture_height,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [wcm_pkg::HGT_W-1:0]     out_rem,
   output logic [wcm_pkg::TROW_Q-1:0]    out_dvd,
   output wcm_pkg::wcm_side_type         out_side
);

   localparam int TW    = $clog2(TILE_PIXELS + 1);
   localparam int SCR_W = 7 + TW;
   localparam int LW    = ((SCR_W + 8) > wcm_pkg::HGT_W ? (SCR_W + 8) : wcm_pkg::HGT_W) + 2;
   localparam int EW    = LW + 2;
   localparam int DFW   = LW - 8;
   localparam int MW    = DFW + 11;

   logic                         v1_ff, v2_ff, v3_ff;
   logic                         e1, e2, e3;
   wcm_pkg::wcm_side_type        s1_side_ff, s1_side_in;
   wcm_pkg::wcm_side_type        s2_side_ff;
   wcm_pkg::wcm_side_type        s3_side_ff, s3_side_in;
   logic [DFW-1:0]               s1_diff_ff, s1_diff_in;
   logic [MW-1:0]                s2_m_ff, s2_m_in;
   logic [wcm_pkg::HGT_W-1:0]    s3_rem_ff;
   logic [wcm_pkg::TROW_Q-1:0]   s3_dvd_ff;
   logic [SCR_W-1:0]             scr;
   logic [wcm_pkg::HGT_W-1:0]    h8;
   logic signed [LW-1:0]         s256, h8s, dd, st;
   logic signed [EW-1:0]         ste, ee, end_row, first, last, rows;
   logic                         tall;

   assign e3       = !v3_ff || out_ready;
   assign e2       = !v2_ff || e3;
   assign e1       = !v1_ff || e2;
   assign in_ready = e1;

   always_comb begin
      scr  = SCR_W'(map_rows) * SCR_W'(TILE_PIXELS);
      h8   = in_side.sat ? wcm_pkg::HEIGHT_SAT : in_quo;
      s256 = $signed(LW'({scr, 8'b0}));
      h8s  = $signed(LW'(h8));
      dd   = s256 - h8s;
      // halve toward zero, as the start may sit above the screen
      st      = (dd < 0) ? -((-dd) >>> 9) : (dd >>> 9);
      ste     = EW'(st);
      ee      = (ste <<< 8) + $signed(EW'(h8));
      end_row = (ee < 0) ? -((-ee) >>> 8) : (ee >>> 8);
      tall    = h8s > s256;
      first   = tall ? '0 : ste;
      last    = tall ? $signed(EW'(scr)) : end_row;
      rows    = $signed(EW'(in_side.row));

      s1_side_in      = in_side;
      s1_side_in.h8   = h8;
      s1_side_in.draw = in_side.cpos && (h8 != '0) && (rows >= first) && (rows < last);
      s1_diff_in      = DFW'(rows - ste);
   end

   assign s2_m_in = MW'(s1_diff_ff) * MW'(texture_height);

   always_comb begin
      // quotient past the 11-bit range already lies beyond any texture height
      s3_side_in     = s2_side_ff;
      s3_side_in.ovf = (s2_m_ff >> 3) >= MW'(s2_side_ff.h8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (e1) begin
            v1_ff <= in_valid;
         end
         if (e2) begin
            v2_ff <= v1_ff;
         end
         if (e3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e1) begin
         s1_side_ff <= s1_side_in;
         s1_diff_ff <= s1_diff_in;
      end
      if (e2) begin
         s2_side_ff <= s1_side_ff;
         s2_m_ff    <= s2_m_in;
      end
      if (e3) begin
         s3_side_ff <= s3_side_in;
         s3_rem_ff  <= s2_m_ff[3 +: wcm_pkg::HGT_W];
         s3_dvd_ff  <= {s2_m_ff[2:0], 8'b0};
      end
   end

   assign out_valid = v3_ff;
   assign out_rem   = s3_rem_ff;
   assign out_dvd   = s3_dvd_ff;
   assign out_side  = s3_side_ff;

endmodule

FILE: hdl/wall_column_texel_mapper_top.sv
// Top level of the wall column texel mapper: register file, divide chains and result stage.
`timescale 1ns / 1ps
// Takes one pixel beat per clock while the result side is not stalled, and returns one result
// beat per pixel, in order. The pipeline is built from three rows of divide cells, one quotient
// bit per cell: 17 for the texel column remainder, 24 for the wall height and 11 for the texel
// row, plus seven setup and output stages. Each stage holds its beat when the next one is full,
// so input is still taken while a result waits.
module wall_column_texel_mapper_top #(
   parameter int TILE_PIXELS = wcm_pkg::TILE_PIXELS_DEF,
   parameter int ANGLE_BITS  = wcm_pkg::ANGLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [wcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [23:0]                      req_ray_distance,
   input  logic [11:0]                      req_ray_angle,
   input  logic [11:0]                      req_view_angle,
   input  logic [23:0]                      req_hit_x,
   input  logic [23:0]                      req_hit_y,
   input  logic                             req_hit_vertical,
   input  logic                             req_face_west_or_north,
   input  logic [9:0]                       req_screen_column,
   input  logic [9:0]                       req_screen_row,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_draw,
   output logic [1:0]                       rsp_texture_select,
   output logic [9:0]                       rsp_texel_column,
   output logic [9:0]                       rsp_texel_row,
   output logic [9:0]                       rsp_out_column,
   output logic [9:0]                       rsp_out_row
);

   localparam int TW    = $clog2(TILE_PIXELS + 1);
   localparam int TPW   = 12 + TW;
   localparam int SW    = wcm_pkg::SIDE_W;
   localparam int NMOD  = wcm_pkg::CRD_W;
   localparam int NHGT  = wcm_pkg::HGT_W;
   localparam int NROW  = wcm_pkg::TROW_Q;
   localparam int RMOD  = wcm_pkg::TCOL_W;
   localparam int RHGT  = wcm_pkg::CD_W;
   localparam int RROW  = wcm_pkg::HGT_W;

   // configuration registers
   logic [11:0] plane_ff;
   logic [6:0]  rows_ff;
   logic [10:0] tw_ff;
   logic [10:0] th_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= wcm_pkg::PLANE_DISTANCE_RST;
         rows_ff  <= wcm_pkg::MAP_ROWS_RST;
         tw_ff    <= wcm_pkg::TEXTURE_WIDTH_RST;
         th_ff    <= wcm_pkg::TEXTURE_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            wcm_pkg::REG_PLANE_DISTANCE: plane_ff <= csr_wdata[11:0];
            wcm_pkg::REG_MAP_ROWS:       rows_ff  <= csr_wdata[6:0];
            wcm_pkg::REG_TEXTURE_WIDTH:  tw_ff    <= csr_wdata[10:0];
            wcm_pkg::REG_TEXTURE_HEIGHT: th_ff    <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // front stage
   logic                      f_valid;
   wcm_pkg::wcm_side_type     f_side;
   logic [NMOD-1:0]           f_coord;

   // texel column remainder chain
   logic                      mv    [0:NMOD];
   logic                      mr    [0:NMOD];
   logic [RMOD-1:0]           mrem  [0:NMOD];
   logic [NMOD-1:0]           mdvd  [0:NMOD];
   logic [RMOD-1:0]           mden  [0:NMOD];
   logic [0:0]                mquo  [0:NMOD];
   logic [SW-1:0]             mside [0:NMOD];

   wcm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_valid),
      .in_ready           (req_ready),
      .ray_distance       (req_ray_distance),
      .ray_angle          (req_ray_angle),
      .view_angle         (req_view_angle),
      .hit_x              (req_hit_x),
      .hit_y              (req_hit_y),
      .hit_vertical       (req_hit_vertical),
      .face_west_or_north (req_face_west_or_north),
      .screen_column      (req_screen_column),
      .screen_row         (req_screen_row),
      .out_valid          (f_valid),
      .out_ready          (mr[0]),
      .out_side           (f_side),
      .out_coord          (f_coord)
   );

   assign mv[0]    = f_valid;
   assign mrem[0]  = '0;
   assign mdvd[0]  = f_coord;
   assign mden[0]  = tw_ff;
   assign mquo[0]  = '0;
   assign mside[0] = f_side;

   for (genvar g = 0; g < NMOD; g++) begin : g_mod
      wcm_div_cell #(.RW(RMOD), .DW(NMOD), .QW(1), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (mv[g]),
         .in_ready  (mr[g]),
         .in_rem    (mrem[g]),
         .in_dvd    (mdvd[g]),
         .in_den    (mden[g]),
         .in_quo    (mquo[g]),
         .in_side   (mside[g]),
         .out_valid (mv[g+1]),
         .out_ready (mr[g+1]),
         .out_rem   (mrem[g+1]),
         .out_dvd   (mdvd[g+1]),
         .out_den   (mden[g+1]),
         .out_quo   (mquo[g+1]),
         .out_side  (mside[g+1])
      );
   end

   // P1: finish texel column, form corrected distance
   logic                      p1_v_ff, p1_en;
   wcm_pkg::wcm_side_type     p1_side_ff, p1_side_in, m_side;
   logic [RHGT-1:0]           p1_cd_ff, p1_cd_in;

   // P2: saturation check and height division setup
   logic                      p2_v_ff, p2_en;
   wcm_pkg::wcm_side_type     p2_side_ff, p2_side_in;
   logic [RHGT-1:0]           p2_rem_ff, p2_cd_ff, p2_top;
   logic [TPW-1:0]            tp;

   // height chain
   logic                      hv    [0:NHGT];
   logic                      hr    [0:NHGT];
   logic [RHGT-1:0]           hrem  [0:NHGT];
   logic [NHGT-1:0]           hdvd  [0:NHGT];
   logic [RHGT-1:0]           hden  [0:NHGT];
   logic [NHGT-1:0]           hquo  [0:NHGT];
   logic [SW-1:0]             hside [0:NHGT];

   assign m_side = wcm_pkg::wcm_side_type'(mside[NMOD]);
   assign p2_en  = !p2_v_ff || hr[0];
   assign p1_en  = !p1_v_ff || p2_en;
   assign mr[NMOD] = p1_en;

   always_comb begin
      p1_side_in = m_side;
      if (tw_ff == '0) begin
         p1_side_in.tcol = '0;
      end else if (mrem[NMOD] > RMOD'(wcm_pkg::FIELD_MAX)) begin
         p1_side_in.tcol = wcm_pkg::FIELD_MAX;
      end else begin
         p1_side_in.tcol = mrem[NMOD][9:0];
      end
      p1_cd_in = RHGT'(m_side.ray_dist) * RHGT'(m_side.cmag);

      // height overflows 24 bits when the top of the dividend reaches the divisor
      tp             = TPW'(plane_ff) * TPW'(TILE_PIXELS);
      p2_top         = RHGT'({tp, 6'b0});
      p2_side_in     = p1_side_ff;
      p2_side_in.sat = p2_top >= p1_cd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         if (p1_en) begin
            p1_v_ff <= mv[NMOD];
         end
         if (p2_en) begin
            p2_v_ff <= p1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_en) begin
         p1_side_ff <= p1_side_in;
         p1_cd_ff   <= p1_cd_in;
      end
      if (p2_en) begin
         p2_side_ff <= p2_side_in;
         p2_rem_ff  <= p2_top;
         p2_cd_ff   <= p1_cd_ff;
      end
   end

   assign hv[0]    = p2_v_ff;
   assign hrem[0]  = p2_rem_ff;
   assign hdvd[0]  = '0;
   assign hden[0]  = p2_cd_ff;
   assign hquo[0]  = '0;
   assign hside[0] = p2_side_ff;

   for (genvar g = 0; g < NHGT; g++) begin : g_hgt
      wcm_div_cell #(.RW(RHGT), .DW(NHGT), .QW(NHGT), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (hv[g]),
         .in_ready  (hr[g]),
         .in_rem    (hrem[g]),
         .in_dvd    (hdvd[g]),
         .in_den    (hden[g]),
         .in_quo    (hquo[g]),
         .in_side   (hside[g]),
         .out_valid (hv[g+1]),
         .out_ready (hr[g+1]),
         .out_rem   (hrem[g+1]),
         .out_dvd   (hdvd[g+1]),
         .out_den   (hden[g+1]),
         .out_quo   (hquo[g+1]),
         .out_side  (hside[g+1])
      );
   end

   // slice placement and texel row setup
   logic                      s_valid;
   logic [RROW-1:0]           s_rem;
   logic [NROW-1:0]           s_dvd;
   wcm_pkg::wcm_side_type     s_side;

   // texel row chain
   logic                      rv    [0:NROW];
   logic                      rr    [0:NROW];
   logic [RROW-1:0]           rrem  [0:NROW];
   logic [NROW-1:0]           rdvd  [0:NROW];
   logic [RROW-1:0]           rden  [0:NROW];
   logic [NROW-1:0]           rquo  [0:NROW];
   logic [SW-1:0]             rside [0:NROW];

   wcm_slice #(.TILE_PIXELS(TILE_PIXELS)) u_slice (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (hv[NHGT]),
      .in_ready       (hr[NHGT]),
      .in_quo         (hquo[NHGT]),
      .in_side        (wcm_pkg::wcm_side_type'(hside[NHGT])),
      .map_rows       (rows_ff),
      .texture_height (th_ff),
      .out_valid      (s_valid),
      .out_ready      (rr[0]),
      .out_rem        (s_rem),
      .out_dvd        (s_dvd),
      .out_side       (s_side)
   );

   assign rv[0]    = s_valid;
   assign rrem[0]  = s_rem;
   assign rdvd[0]  = s_dvd;
   assign rden[0]  = s_side.h8;
   assign rquo[0]  = '0;
   assign rside[0] = s_side;

   for (genvar g = 0; g < NROW; g++) begin : g_row
      wcm_div_cell #(.RW(RROW), .DW(NROW), .QW(NROW), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rv[g]),
         .in_ready  (rr[g]),
         .in_rem    (rrem[g]),
         .in_dvd    (rdvd[g]),
         .in_den    (rden[g]),
         .in_quo    (rquo[g]),
         .in_side   (rside[g]),
         .out_valid (rv[g+1]),
         .out_ready (rr[g+1]),
         .out_rem   (rrem[g+1]),
         .out_dvd   (rdvd[g+1]),
         .out_den   (rden[g+1]),
         .out_quo   (rquo[g+1]),
         .out_side  (rside[g+1])
      );
   end

   // result stage
   logic                      o_v_ff, o_en;
   wcm_pkg::wcm_side_type     t_side;
   logic [NROW-1:0]           lim;
   logic [9:0]                trow_in, trow_ff;
   logic                      draw_ff;
   logic [1:0]                sel_ff;
   logic [9:0]                tcol_ff, col_ff, row_ff;

   assign t_side   = wcm_pkg::wcm_side_type'(rside[NROW]);
   assign o_en     = !o_v_ff || rsp_ready;
   assign rr[NROW] = o_en;

   always_comb begin
      if (t_side.ovf || (rquo[NROW] >= th_ff)) begin
         lim = th_ff - 11'd1;
      end else begin
         lim = rquo[NROW];
      end
      if (!t_side.draw || (th_ff == '0)) begin
         trow_in = '0;
      end else if (lim > NROW'(wcm_pkg::FIELD_MAX)) begin
         trow_in = wcm_pkg::FIELD_MAX;
      end else begin
         trow_in = lim[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_en) begin
         o_v_ff <= rv[NROW];
      end
   end

   always_ff @(posedge clock) begin
      if (o_en) begin
         draw_ff <= t_side.draw;
         sel_ff  <= t_side.sel;
         tcol_ff <= t_side.tcol;
         trow_ff <= trow_in;
         col_ff  <= t_side.col;
         row_ff  <= t_side.row;
      end
   end

   assign rsp_valid          = o_v_ff;
   assign rsp_draw           = draw_ff;
   assign rsp_texture_select = sel_ff;
   assign rsp_texel_column   = tcol_ff;
   assign rsp_texel_row      = trow_ff;
   assign rsp_out_column     = col_ff;
   assign rsp_out_row        = row_ff;

endmodule

FILE: hdl/wcm_checker.sv
// Port-level checks of the wall column texel mapper, bound to the top level.
`timescale 1ns / 1ps
module wcm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_draw,
   input logic [1:0] rsp_texture_select,
   input logic [9:0] rsp_texel_column,
   input logic [9:0] rsp_texel_row,
   input logic [9:0] rsp_out_column,
   input logic [9:0] rsp_out_row
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_draw)
         && $stable(rsp_texture_select) && $stable(rsp_texel_column)
         && $stable(rsp_texel_row) && $stable(rsp_out_column) && $stable(rsp_out_row))
      else $error("result beat changed while stalled");

   // reset drains the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // undrawn pixels carry texel row zero
   a_undrawn_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_draw |-> rsp_texel_row == 10'd0)
      else $error("texel row set on undrawn pixel");

endmodule

bind wall_column_texel_mapper_top wcm_checker u_wcm_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench of the wall column texel mapper: directed table, then random beats.
`timescale 1ns / 1ps
module tb_top;

   localparam int TILE = 32;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [23:0] ray_dist;
      logic [11:0] ray_ang;
      logic [11:0] view_ang;
      logic [23:0] hx;
      logic [23:0] hy;
      logic        vert;
      logic        face;
      logic [9:0]  col;
      logic [9:0]  row;
   } pixel_type;

   typedef struct packed {
      logic       draw;
      logic [1:0] sel;
      logic [9:0] tcol;
      logic [9:0] trow;
      logic [9:0] col;
      logic [9:0] row;
   } texel_type;

   typedef struct {
      pixel_type px;
      bit        typed;
      texel_type want;
   } dir_row_type;

   logic        clock, reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [11:0] csr_wdata;
   logic        req_valid, req_ready;
   pixel_type   req_px;
   logic        rsp_valid, rsp_ready;
   texel_type   rsp_tx;

   int unsigned plane_dist, map_rows, tex_w, tex_h;
   texel_type   expected_texels[$];
   int          errors;
   bit          stim_done;

   wall_column_texel_mapper_top dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ray_distance(req_px.ray_dist), .req_ray_angle(req_px.ray_ang),
      .req_view_angle(req_px.view_ang), .req_hit_x(req_px.hx), .req_hit_y(req_px.hy),
      .req_hit_vertical(req_px.vert), .req_face_west_or_north(req_px.face),
      .req_screen_column(req_px.col), .req_screen_row(req_px.row),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_draw(rsp_tx.draw), .rsp_texture_select(rsp_tx.sel),
      .rsp_texel_column(rsp_tx.tcol), .rsp_texel_row(rsp_tx.trow),
      .rsp_out_column(rsp_tx.col), .rsp_out_row(rsp_tx.row)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb_top: errors");
      $finish;
   end

   function automatic int cosine_q14(input logic [15:0] a16);
      int tbl[17] = '{16384, 16305, 16069, 15679, 15137, 14449, 13623, 12665, 11585,
                      10394, 9102, 7723, 6270, 4756, 3196, 1606, 0};
      logic [1:0] quad;
      int x, i, f, v;
      quad = a16[15:14];
      x = (quad[0]) ? (16384 - a16[13:0]) : a16[13:0];
      i = x >> 10;
      f = x & 1023;
      if (i >= 16) v = 0;
      else v = tbl[i] - (((tbl[i] - tbl[i+1]) * f + 512) >> 10);
      return (quad == 2'd1 || quad == 2'd2) ? -v : v;
   endfunction

   function automatic texel_type map_texel(input pixel_type p);
      texel_type t;
      longint unsigned coord, tcol, cd, num, h8, trow;
      longint scr, start, stop, first, row;
      logic [11:0] delta;
      int c;
      t = '0;
      t.col = p.col;
      t.row = p.row;
      row = p.row;
      t.sel = p.vert ? (p.face ? wcm_pkg::TEX_WEST : wcm_pkg::TEX_EAST)
                     : (p.face ? wcm_pkg::TEX_NORTH : wcm_pkg::TEX_SOUTH);
      coord = p.vert ? p.hy : p.hx;
      tcol = 0;
      if (tex_w != 0) tcol = ((coord + 128) >> 8) % tex_w;
      if (tcol > 1023) tcol = 1023;
      t.tcol = tcol[9:0];
      delta = p.ray_ang - p.view_ang;
      c = cosine_q14({delta, 4'b0});
      if (c > 0) begin
         cd = longint'(p.ray_dist) * c;
         num = (longint'(TILE) * plane_dist) << 30;
         h8 = (cd == 0) ? 64'hFFFFFF : num / cd;
         if (h8 > 64'hFFFFFF) h8 = 64'hFFFFFF;
         scr = longint'(map_rows) * TILE;
         start = (scr * 256 - longint'(h8)) / 512;
         stop = (start * 256 + longint'(h8)) / 256;
         first = start;
         if (longint'(h8) > scr * 256) begin
            stop = scr;
            first = 0;
         end
         if (h8 > 0 && row >= first && row < stop) begin
            t.draw = 1'b1;
            trow = (longint'(row - start) * tex_h * 256) / h8;
            if (tex_h == 0) trow = 0;
            else if (trow >= tex_h) trow = tex_h - 1;
            if (trow > 1023) trow = 1023;
            t.trow = trow[9:0];
         end
      end
      return t;
   endfunction

   // write one register; block must be idle, caller drops the enable after the last one
   task automatic write_reg(input logic [2:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[11:0];
      @(posedge clock);
      case (idx)
         wcm_pkg::REG_PLANE_DISTANCE: plane_dist = val & 12'hFFF;
         wcm_pkg::REG_MAP_ROWS:       map_rows = val & 7'h7F;
         wcm_pkg::REG_TEXTURE_WIDTH:  tex_w = val & 12'hFFF & 11'h7FF;
         wcm_pkg::REG_TEXTURE_HEIGHT: tex_h = val & 12'hFFF & 11'h7FF;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (expected_texels.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type p, input bit typed, input texel_type want);
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3))
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_px <= p;
      expected_texels.push_back(typed ? want : map_texel(p));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic pixel_type rand_pixel();
      pixel_type p;
      int d;
      p = '0;
      d = $urandom_range(0, 9);
      if (d == 0) p.ray_dist = 24'($urandom());
      else if (d == 1) p.ray_dist = 24'($urandom_range(0, 255));
      else p.ray_dist = 24'($urandom_range(64, 4096 * 4));
      p.view_ang = 12'($urandom());
      p.ray_ang = ($urandom_range(0, 5) == 0) ? 12'($urandom())
                  : 12'(p.view_ang + $urandom_range(0, 1400) - 700);
      p.hx = 24'($urandom());
      p.hy = 24'($urandom());
      p.vert = 1'($urandom());
      p.face = 1'($urandom());
      p.col = 10'($urandom());
      p.row = ($urandom_range(0, 4) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 400));
      return p;
   endfunction

   // drain and check result beats
   always @(posedge clock) begin
      texel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_texels.size() == 0) begin
            $display("%0t unexpected beat: got %p", $time, rsp_tx);
            errors++;
         end else begin
            want = expected_texels.pop_front();
            if (rsp_tx.draw !== want.draw)
               $display("%0t draw: exp %0d got %0d", $time, want.draw, rsp_tx.draw);
            if (rsp_tx.sel !== want.sel)
               $display("%0t texture_select: exp %0d got %0d", $time, want.sel, rsp_tx.sel);
            if (rsp_tx.tcol !== want.tcol)
               $display("%0t texel_column: exp %0d got %0d", $time, want.tcol, rsp_tx.tcol);
            if (rsp_tx.trow !== want.trow)
               $display("%0t texel_row: exp %0d got %0d", $time, want.trow, rsp_tx.trow);
            if (rsp_tx.col !== want.col)
               $display("%0t out_column: exp %0d got %0d", $time, want.col, rsp_tx.col);
            if (rsp_tx.row !== want.row)
               $display("%0t out_row: exp %0d got %0d", $time, want.row, rsp_tx.row);
            if (rsp_tx !== want) errors++;
         end
      end
   end

   // result-side stalls, with calm stretches
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset || stim_done) rsp_ready <= 1'b1;
      else if ((($time / 20000) % 3) == 0) rsp_ready <= 1'b1;
      else if (r < 3) rsp_ready <= 1'b0;
      else if (r < 25) rsp_ready <= ~rsp_ready | (r < 12);
      else rsp_ready <= 1'b1;
   end

   initial begin
      dir_row_type dirs[$];
      dir_row_type d;
      int unsigned cfg[4][4] = '{'{4095, 64, 1024, 1024}, '{1, 1, 1, 1},
                                 '{277, 10, 0, 0}, '{1000, 20, 37, 300}};
      errors = 0;
      stim_done = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_px = '0;
      plane_dist = 277; map_rows = 10; tex_w = 64; tex_h = 64;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // not drawn: perpendicular angle, texel_row zero, select west
      d.px = '0; d.px.ray_ang = 12'd1024; d.px.vert = 1; d.px.face = 1;
      d.px.hy = 24'd200; d.px.row = 10'd5; d.px.col = 10'd1023;
      d.typed = 1; d.want = '{1'b0, wcm_pkg::TEX_WEST, 10'd1, 10'd0, 10'd1023, 10'd5};
      dirs.push_back(d);
      // zero distance saturates: draws rows below the screen height, select north, then south
      d.px = '0; d.px.face = 1; d.px.hx = 24'hFFFFFF; d.px.row = 10'd0;
      d.typed = 0; dirs.push_back(d);
      d.px.row = 10'd319; dirs.push_back(d);
      d.px.row = 10'd320; dirs.push_back(d);
      d.px.row = 10'd1023; d.px.face = 0; dirs.push_back(d);
      // opposite direction, max distance, east; then an all-ones pixel, west
      d.px = '1; d.px.ray_ang = 12'd2048; d.px.view_ang = 0; d.px.face = 0;
      dirs.push_back(d);
      d.px = '1; dirs.push_back(d);
      for (int r = 140; r < 180; r += 5) begin
         d.px = '0; d.px.ray_dist = 24'd16384; d.px.row = 10'(r); d.px.ray_ang = 12'd4095;
         d.px.hx = 24'(r * 997); dirs.push_back(d);
      end
      d.px = '0; d.px.ray_dist = 24'd1; d.px.ray_ang = 12'd1023; d.px.row = 10'd160;
      dirs.push_back(d);
      d.px.ray_ang = 12'd3073; dirs.push_back(d);
      foreach (dirs[i]) send_pixel(dirs[i].px, dirs[i].typed, dirs[i].want);
      req_valid <= 1'b0;
      wait_idle();

      for (int ph = 0; ph < 5; ph++) begin
         if (ph < 4) begin
            write_reg(wcm_pkg::REG_PLANE_DISTANCE, cfg[ph][0]);
            write_reg(wcm_pkg::REG_MAP_ROWS, cfg[ph][1]);
            write_reg(wcm_pkg::REG_TEXTURE_WIDTH, cfg[ph][2]);
            write_reg(wcm_pkg::REG_TEXTURE_HEIGHT, cfg[ph][3]);
         end else begin
            write_reg(3'd5, 12'hABC);
            write_reg(wcm_pkg::REG_MAP_ROWS, 0);
            write_reg(wcm_pkg::REG_PLANE_DISTANCE, $urandom_range(1, 4095));
         end
         csr_we <= 1'b0;
         for (int n = 0; n < 230; n++) begin
            send_pixel(rand_pixel(), 0, '0);
            // hold off until the pipe is empty
            if (n == 100) begin
               req_valid <= 1'b0;
               while (expected_texels.size() != 0) @(posedge clock);
            end
         end
         req_valid <= 1'b0;
         wait_idle();
      end
      stim_done = 1;

      fork
         while (expected_texels.size() != 0) @(posedge clock);
         repeat (20000) @(posedge clock);
      join_any
      disable fork;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_texels.size() == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end
endmodule

FILE: filelist.f
hdl/wcm_pkg.sv
hdl/wcm_div_cell.sv
hdl/wcm_front.sv
hdl/wcm_slice.sv
hdl/wall_column_texel_mapper_top.sv
hdl/wcm_checker.sv
sim/tb_top.sv
